// File: sv/tlrgb_pkg.sv
// Shared types, widths, register codes and reset values for the three-lane
// RGB LED bit encoder. No dependencies; every file but tlrgb_ram uses it by scoped names.
package tlrgb_pkg;

   // Default sizing handed to the top level parameters
   localparam int LED_COUNT_DEF = 32;
   localparam int LANES_DEF     = 3;

   // Fixed widths of the payload fields
   localparam int LANE_OUTS  = 3;
   localparam int COLOR_BITS = 24;
   localparam int BIT_W      = 5;
   localparam int SPLIT_W    = 8;
   localparam int CMP_W      = 16;
   localparam int INDEX_W    = 8;
   localparam int REQ_DATA_W = 32;
   localparam int RSP_DATA_W = 64;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 16;

   // Register reset values
   localparam logic [SPLIT_W-1:0] FIRST_SPLIT_RST  = 8'd27;
   localparam logic [SPLIT_W-1:0] SECOND_SPLIT_RST = 8'd55;
   localparam logic [CMP_W-1:0]   BIT_PERIOD_RST   = 16'd95;
   localparam logic [CMP_W-1:0]   RESET_PERIOD_RST = 16'd1199;
   localparam logic [CMP_W-1:0]   ONE_CMP_RST      = 16'd9;
   localparam logic [CMP_W-1:0]   ZERO_CMP_RST     = 16'd4;

   // Configuration register indexes
   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_FIRST_SPLIT  = 3'd0,
      CSR_SECOND_SPLIT = 3'd1,
      CSR_BIT_PERIOD   = 3'd2,
      CSR_RESET_PERIOD = 3'd3,
      CSR_ONE_CMP      = 3'd4,
      CSR_ZERO_CMP     = 3'd5
   } csr_idx_type;

   // Request kinds carried on tuser
   typedef enum logic {
      CMD_TICK  = 1'b0,
      CMD_WRITE = 1'b1
   } cmd_type;

   // Live configuration seen by the datapath
   typedef struct packed {
      logic [SPLIT_W-1:0] first_split;
      logic [SPLIT_W-1:0] second_split;
      logic [CMP_W-1:0]   bit_period;
      logic [CMP_W-1:0]   reset_period;
      logic [CMP_W-1:0]   one_compare;
      logic [CMP_W-1:0]   zero_compare;
   } cfg_type;

   // Tick in flight between the read stage and the output stage
   typedef struct packed {
      logic             valid;
      logic             latch;
      logic [BIT_W-1:0] bit_pos;
   } slot_ctl_type;

endpackage

// File: sv/tlrgb_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
module tlrgb_ram #(
   parameter int WIDTH = 24,
   parameter int DEPTH = 32
) (
   input  logic                                          clock,
   input  logic                                          wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0]  wr_addr,
   input  logic [WIDTH-1:0]                              wr_data,
   input  logic                                          rd_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0]  rd_addr,
   output logic [WIDTH-1:0]                              rd_data
);
   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // Registered read port
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;
endmodule

// File: sv/tlrgb_csr.sv
// Configuration register file for the LED bit encoder.
// Depends on tlrgb_pkg for the register codes, reset values and cfg_type.
module tlrgb_csr (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             csr_valid,
   output logic                             csr_ready,
   input  logic [tlrgb_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [tlrgb_pkg::CSR_DATA_W-1:0] csr_data,
   output tlrgb_pkg::cfg_type               cfg
);
   tlrgb_pkg::cfg_type cfg_ff;
   tlrgb_pkg::cfg_type cfg_in;

   // Decode the write; unknown indexes leave everything alone
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         unique case (tlrgb_pkg::csr_idx_type'(csr_index))
            tlrgb_pkg::CSR_FIRST_SPLIT:  cfg_in.first_split  = csr_data[tlrgb_pkg::SPLIT_W-1:0];
            tlrgb_pkg::CSR_SECOND_SPLIT: cfg_in.second_split = csr_data[tlrgb_pkg::SPLIT_W-1:0];
            tlrgb_pkg::CSR_BIT_PERIOD:   cfg_in.bit_period   = csr_data;
            tlrgb_pkg::CSR_RESET_PERIOD: cfg_in.reset_period = csr_data;
            tlrgb_pkg::CSR_ONE_CMP:      cfg_in.one_compare  = csr_data;
            tlrgb_pkg::CSR_ZERO_CMP:     cfg_in.zero_compare = csr_data;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.first_split  <= tlrgb_pkg::FIRST_SPLIT_RST;
         cfg_ff.second_split <= tlrgb_pkg::SECOND_SPLIT_RST;
         cfg_ff.bit_period   <= tlrgb_pkg::BIT_PERIOD_RST;
         cfg_ff.reset_period <= tlrgb_pkg::RESET_PERIOD_RST;
         cfg_ff.one_compare  <= tlrgb_pkg::ONE_CMP_RST;
         cfg_ff.zero_compare <= tlrgb_pkg::ZERO_CMP_RST;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign csr_ready = 1'b1;
   assign cfg       = cfg_ff;
endmodule

// File: sv/tlrgb_slot.sv
// Output stage: picks the current color bit of each lane, maps it to a compare
// value and holds the finished word for the result channel. Depends on tlrgb_pkg.
module tlrgb_slot #(
   parameter int LANES = tlrgb_pkg::LANES_DEF
) (
   input  logic                                                 clock,
   input  logic                                                 reset,
   input  tlrgb_pkg::cfg_type                                   cfg,
   input  tlrgb_pkg::slot_ctl_type                              ctl,
   input  logic [tlrgb_pkg::LANE_OUTS-1:0][tlrgb_pkg::COLOR_BITS-1:0] lane_word,
   output logic                                                 free,
   output logic                                                 rsp_tvalid,
   input  logic                                                 rsp_tready,
   output logic [tlrgb_pkg::RSP_DATA_W-1:0]                     rsp_tdata,
   output logic                                                 rsp_tuser
);
   logic                                 rsp_valid_ff;
   logic [tlrgb_pkg::RSP_DATA_W-1:0]     rsp_data_ff;
   logic [tlrgb_pkg::RSP_DATA_W-1:0]     rsp_data_in;
   logic                                 rsp_user_ff;
   logic [tlrgb_pkg::BIT_W-1:0]          bit_sel;
   logic [tlrgb_pkg::LANE_OUTS-1:0][tlrgb_pkg::CMP_W-1:0] cmp;

   // Colors go out msb first
   assign bit_sel = tlrgb_pkg::BIT_W'(tlrgb_pkg::COLOR_BITS - 1) - ctl.bit_pos;

   // Map each lane bit to its compare value; absent lanes and the latch gap read zero
   always_comb begin
      for (int g = 0; g < tlrgb_pkg::LANE_OUTS; g++) begin
         if (ctl.latch || g >= LANES) begin
            cmp[g] = '0;
         end else if (lane_word[g][bit_sel]) begin
            cmp[g] = cfg.one_compare;
         end else begin
            cmp[g] = cfg.zero_compare;
         end
      end
      rsp_data_in = {cmp[2], cmp[1], cmp[0],
                     ctl.latch ? cfg.reset_period : cfg.bit_period};
   end

   // Output register advances whenever it is empty or being taken
   assign free = !rsp_valid_ff || rsp_tready;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (free) begin
         rsp_valid_ff <= ctl.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (free && ctl.valid) begin
         rsp_data_ff <= rsp_data_in;
         rsp_user_ff <= ctl.latch;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_user_ff;
endmodule

// File: sv/three_lane_rgb_led_bit_encoder_top.sv
// Three-lane RGB LED bit encoder: frame store, write decode, bit and LED
// counters, clearing pass. Uses tlrgb_pkg, tlrgb_csr, tlrgb_ram and tlrgb_slot.
//
// Usage:
//  - req channel: tuser = command (0 tick, 1 color write); tdata holds
//    led_index in [7:0] and color in [31:8]. A write stores one color in
//    the lane picked by the two split registers and returns nothing; an
//    index that lands outside a lane's LED_COUNT entries is dropped.
//  - rsp channel: one word per tick. tdata holds period, then the compare
//    values of lanes 0, 1 and 2; tuser flags the latch gap that follows
//    the last bit of LED_COUNT LEDs and restarts the frame.
//  - csr channel: always ready; write only while the block is idle.
//  - Path: an accepted tick passes through the read stage, where the frame
//    RAM's read data arrives, and then the output register that drives rsp_tvalid.
//    Throughput: one word per cycle while rsp_tready is high; the frame RAM's registered read port
//    sets the extra stage in front of the output register.
//  - Reset: registers return to their defaults and a clearing pass zeroes
//    the frame store, one entry per lane per cycle, with req_tready low;
//    csr writes are taken throughout.
//  - Stall: the output register holds its word while rsp_tready is low;
//    one more tick is taken into the read stage, then req_tready drops.
//    Color writes share the same ready.
module three_lane_rgb_led_bit_encoder_top #(
   parameter int LED_COUNT = tlrgb_pkg::LED_COUNT_DEF,
   parameter int LANES     = tlrgb_pkg::LANES_DEF
) (
   input  logic                             clock,
   input  logic                             reset,
   // req
   input  logic                             req_tvalid,
   output logic                             req_tready,
   input  logic [tlrgb_pkg::REQ_DATA_W-1:0] req_tdata,  // led_index[7:0], color[31:8]
   input  logic                             req_tuser,  // command[0]
   // rsp
   output logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   output logic [tlrgb_pkg::RSP_DATA_W-1:0] rsp_tdata,  // period, compare_lane0..2
   output logic                             rsp_tuser,  // latch_slot[0]
   // csr
   input  logic                             csr_valid,
   output logic                             csr_ready,
   input  logic [tlrgb_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [tlrgb_pkg::CSR_DATA_W-1:0] csr_data
);
   localparam int AW = (LED_COUNT > 1) ? $clog2(LED_COUNT) : 1;
   localparam int PW = $clog2(LED_COUNT + 1);

   tlrgb_pkg::cfg_type      cfg;
   tlrgb_pkg::slot_ctl_type s1_ff;
   tlrgb_pkg::slot_ctl_type s1_in;

   logic                                 clear_ff;
   logic [AW-1:0]                        clear_addr_ff;
   logic [PW-1:0]                        led_pos_ff;
   logic [PW-1:0]                        led_pos_in;
   logic [tlrgb_pkg::BIT_W-1:0]          bit_pos_ff;
   logic [tlrgb_pkg::BIT_W-1:0]          bit_pos_in;

   logic                                 free;
   logic                                 accept;
   logic                                 tick_acc;
   logic                                 write_acc;
   logic                                 at_latch;
   logic [tlrgb_pkg::INDEX_W-1:0]        wr_index;
   logic [tlrgb_pkg::COLOR_BITS-1:0]     wr_color;
   logic [1:0]                           wr_lane;
   logic [tlrgb_pkg::INDEX_W-1:0]        wr_pos;
   logic                                 wr_ok;
   logic [AW-1:0]                        ram_wr_addr;
   logic [tlrgb_pkg::COLOR_BITS-1:0]     ram_wr_data;
   logic [tlrgb_pkg::LANE_OUTS-1:0][tlrgb_pkg::COLOR_BITS-1:0] lane_word;

   tlrgb_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .cfg       (cfg)
   );

   // Handshake: hold off during the clearing pass and while the read stage is stuck
   assign req_tready = !clear_ff && (!s1_ff.valid || free);
   assign accept     = req_tvalid && req_tready;
   assign tick_acc   = accept && (tlrgb_pkg::cmd_type'(req_tuser) == tlrgb_pkg::CMD_TICK);
   assign write_acc  = accept && (tlrgb_pkg::cmd_type'(req_tuser) == tlrgb_pkg::CMD_WRITE);
   assign at_latch   = (led_pos_ff == PW'(LED_COUNT));

   // Split the global index into lane and position
   assign wr_index = req_tdata[tlrgb_pkg::INDEX_W-1:0];
   assign wr_color = req_tdata[tlrgb_pkg::REQ_DATA_W-1:tlrgb_pkg::INDEX_W];

   always_comb begin
      if (wr_index < cfg.first_split) begin
         wr_lane = 2'd0;
         wr_pos  = wr_index;
      end else if (wr_index < cfg.second_split) begin
         wr_lane = 2'd1;
         wr_pos  = wr_index - cfg.first_split;
      end else begin
         wr_lane = 2'd2;
         wr_pos  = wr_index - cfg.second_split;
      end
      wr_ok = write_acc && (32'(wr_lane) < 32'(LANES)) && (32'(wr_pos) < 32'(LED_COUNT));
   end

   assign ram_wr_addr = clear_ff ? clear_addr_ff : AW'(wr_pos);
   assign ram_wr_data = clear_ff ? '0 : wr_color;

   // Frame store, one RAM per lane
   for (genvar g = 0; g < tlrgb_pkg::LANE_OUTS; g++) begin : g_lane
      if (g < LANES) begin : g_ram
         tlrgb_ram #(
            .WIDTH (tlrgb_pkg::COLOR_BITS),
            .DEPTH (LED_COUNT)
         ) u_ram (
            .clock   (clock),
            .wr_en   (clear_ff || (wr_ok && wr_lane == 2'(g))),
            .wr_addr (ram_wr_addr),
            .wr_data (ram_wr_data),
            .rd_en   (tick_acc && !at_latch),
            .rd_addr (led_pos_ff[AW-1:0]),
            .rd_data (lane_word[g])
         );
      end else begin : g_none
         assign lane_word[g] = '0;
      end
   end

   // Clearing pass after reset
   always_ff @(posedge clock) begin
      if (reset) begin
         clear_ff      <= 1'b1;
         clear_addr_ff <= '0;
      end else if (clear_ff) begin
         clear_addr_ff <= clear_addr_ff + 1'b1;
         if (clear_addr_ff == AW'(LED_COUNT - 1)) begin
            clear_ff <= 1'b0;
         end
      end
   end

   // Advance bit and LED counters on every tick; wrap after the latch gap
   always_comb begin
      led_pos_in = led_pos_ff;
      bit_pos_in = bit_pos_ff;
      if (tick_acc) begin
         if (at_latch) begin
            led_pos_in = '0;
            bit_pos_in = '0;
         end else if (bit_pos_ff == tlrgb_pkg::BIT_W'(tlrgb_pkg::COLOR_BITS - 1)) begin
            bit_pos_in = '0;
            led_pos_in = led_pos_ff + 1'b1;
         end else begin
            bit_pos_in = bit_pos_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         led_pos_ff <= '0;
         bit_pos_ff <= '0;
      end else begin
         led_pos_ff <= led_pos_in;
         bit_pos_ff <= bit_pos_in;
      end
   end

   // Read stage: tick waiting on RAM data
   always_comb begin
      s1_in = s1_ff;
      if (tick_acc) begin
         s1_in.valid   = 1'b1;
         s1_in.latch   = at_latch;
         s1_in.bit_pos = bit_pos_ff;
      end else if (free) begin
         s1_in.valid = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_ff <= '0;
      end else begin
         s1_ff <= s1_in;
      end
   end

   tlrgb_slot #(
      .LANES (LANES)
   ) u_slot (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg),
      .ctl        (s1_ff),
      .lane_word  (lane_word),
      .free       (free),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );
endmodule

// File: sv/tlrgb_chk.sv
// Port-level checker for the LED bit encoder, bound to the top level.
// Depends on tlrgb_pkg for the port widths.
module tlrgb_chk (
   input logic                             clock,
   input logic                             reset,
   input logic                             req_tready,
   input logic                             rsp_tvalid,
   input logic                             rsp_tready,
   input logic [tlrgb_pkg::RSP_DATA_W-1:0] rsp_tdata,
   input logic                             rsp_tuser
);
   // Latch gap carries zero compares on every lane
   a_latch_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser |-> rsp_tdata[tlrgb_pkg::RSP_DATA_W-1:tlrgb_pkg::CMP_W] == '0)
      else $error("latch word with nonzero compare");

   // Clearing pass keeps the request side closed right after reset
   a_clear_hold: assert property (@(posedge clock)
      $fell(reset) |-> !req_tready)
      else $error("request accepted during clearing pass");

   // No result word out of reset
   a_rsp_reset: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("result word valid after reset");

   // Stalled word holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("stalled result word changed");
endmodule

bind three_lane_rgb_led_bit_encoder_top tlrgb_chk u_chk (
   .clock      (clock),
   .reset      (reset),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser)
);
